// File: rtl/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

    localparam int ID_W    = 27;
    localparam int SCORE_W = 10;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FIRST,
        ST_SCAN,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // sort key: id, or score widened to the id width
    function automatic logic [ID_W-1:0] key_of(input rec_t rec, input logic by_score);
        logic [ID_W-1:0] key;
        key = by_score ? {{(ID_W-SCORE_W){1'b0}}, rec.score} : rec.id;
        return key;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ssr_in_if.sv
`default_nettype none

interface ssr_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssr_pkg::ID_W-1:0]    student_id;
    logic [ssr_pkg::SCORE_W-1:0] score;
    logic                        last_record;

    modport source (output valid, student_id, score, last_record, input ready);
    modport sink   (input valid, student_id, score, last_record, output ready);
endinterface

`default_nettype wire

// File: rtl/ssr_out_if.sv
`default_nettype none

interface ssr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ssr_pkg::ID_W-1:0]    out_id;
    logic [ssr_pkg::SCORE_W-1:0] out_score;
    logic                        out_last;
    logic                        overflowed;

    modport source (output valid, out_id, out_score, out_last, overflowed, input ready);
    modport sink   (input valid, out_id, out_score, out_last, overflowed, output ready);
endinterface

`default_nettype wire

// File: rtl/ssr_ram.sv
`default_nettype none

module ssr_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/selection_sort_records.sv
// Record sorter. Words arrive on the records channel (id, score, last flag)
// and are stored one per cycle in a single record RAM, up to DEPTH of them;
// further words of the set are dropped and the set is marked as overflowed.
// The word flagged last starts an in-place selection sort on the key picked
// by sort_by_score (cfg_we/cfg_wdata; 0 = id, 1 = score), then the sorted
// set leaves on the sorted channel, out_last on its final word, and the
// record count and overflow mark clear for the next set.
// Pass i of the sort reads entry i, then each candidate above it (one RAM
// read per candidate), and ends with two writes for the exchange; passes
// run for every i below n - 1. Emission reads the RAM for each word, then
// loads the output register.
// The records channel is not ready during sort and emission. A stall on the
// sorted channel holds the output register and pauses emission; the next
// set may be loaded while the final word of the previous one still waits.
// Reset clears the controller, count, overflow mark and register; the RAM
// needs no clearing, as only entries below the count are ever read.
`default_nettype none

module selection_sort_records #(
    parameter int DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    ssr_in_if.sink    records,
    ssr_out_if.source sorted
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ssr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            drop_reg, drop_next;
    logic            sort_by_score_reg;
    logic [AW-1:0]   i_reg, i_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [AW-1:0]   cmp_reg, cmp_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    ssr_pkg::rec_t   best_rec_reg, best_rec_next;
    ssr_pkg::rec_t   rec_i_reg, rec_i_next;
    logic            out_valid_reg, out_valid_next;
    ssr_pkg::rec_t   out_rec_reg, out_rec_next;
    logic            out_last_reg, out_last_next;
    logic            out_ovf_reg, out_ovf_next;

    logic                      ram_wr_en;
    logic [AW-1:0]             ram_wr_addr;
    logic [ssr_pkg::REC_W-1:0] ram_wr_data;
    logic                      ram_rd_en;
    logic [AW-1:0]             ram_rd_addr;
    logic [ssr_pkg::REC_W-1:0] ram_rd_data;
    ssr_pkg::rec_t             rd_rec;
    ssr_pkg::rec_t             in_rec;
    logic                      in_fire;

    assign rd_rec         = ssr_pkg::rec_t'(ram_rd_data);
    assign in_rec.id      = records.student_id;
    assign in_rec.score   = records.score;
    assign records.ready  = (state_reg == ssr_pkg::ST_IDLE);
    assign in_fire        = records.valid && records.ready;

    assign sorted.valid      = out_valid_reg;
    assign sorted.out_id     = out_rec_reg.id;
    assign sorted.out_score  = out_rec_reg.score;
    assign sorted.out_last   = out_last_reg;
    assign sorted.overflowed = out_ovf_reg;

    ssr_ram #(
        .WIDTH (ssr_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ssr_pkg::ST_IDLE;
            count_reg         <= '0;
            drop_reg          <= 1'b0;
            sort_by_score_reg <= 1'b0;
            i_reg             <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                sort_by_score_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        cmp_reg      <= cmp_next;
        best_idx_reg <= best_idx_next;
        best_rec_reg <= best_rec_next;
        rec_i_reg    <= rec_i_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmp_next       = cmp_reg;
        best_idx_next  = best_idx_reg;
        best_rec_next  = best_rec_reg;
        rec_i_next     = rec_i_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !sorted.ready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[AW-1:0];
        ram_wr_data    = in_rec;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = i_reg;

        case (state_reg)
            ssr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (records.last_record)
                    begin
                        i_next     = '0;
                        state_next = ssr_pkg::ST_START;
                    end
                end
            end

            ssr_pkg::ST_START:
            begin
                // pass i done for all i below n - 1: go emit
                if (CW'(i_reg) + CW'(1) >= count_reg)
                begin
                    i_next     = '0;
                    state_next = ssr_pkg::ST_EMIT_RD;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = i_reg;
                    j_next      = i_reg + AW'(1);
                    state_next  = ssr_pkg::ST_FIRST;
                end
            end

            ssr_pkg::ST_FIRST:
            begin
                rec_i_next    = rd_rec;
                best_rec_next = rd_rec;
                best_idx_next = i_reg;
                ram_rd_en     = 1'b1;
                ram_rd_addr   = j_reg;
                cmp_next      = j_reg;
                j_next        = j_reg + AW'(1);
                state_next    = ssr_pkg::ST_SCAN;
            end

            ssr_pkg::ST_SCAN:
            begin
                // strict less-than keeps the earliest minimum
                if (ssr_pkg::key_of(rd_rec, sort_by_score_reg)
                    < ssr_pkg::key_of(best_rec_reg, sort_by_score_reg))
                begin
                    best_rec_next = rd_rec;
                    best_idx_next = cmp_reg;
                end
                if (CW'(cmp_reg) + CW'(1) == count_reg)
                begin
                    state_next = ssr_pkg::ST_SWAP_LO;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = j_reg;
                    cmp_next    = j_reg;
                    j_next      = j_reg + AW'(1);
                end
            end

            ssr_pkg::ST_SWAP_LO:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = i_reg;
                ram_wr_data = best_rec_reg;
                state_next  = ssr_pkg::ST_SWAP_HI;
            end

            ssr_pkg::ST_SWAP_HI:
            begin
                // minimum already in place writes the same word back
                ram_wr_en   = 1'b1;
                ram_wr_addr = best_idx_reg;
                ram_wr_data = rec_i_reg;
                i_next      = i_reg + AW'(1);
                state_next  = ssr_pkg::ST_START;
            end

            ssr_pkg::ST_EMIT_RD:
            begin
                // read only when the output register frees at this edge
                if (!out_valid_reg || sorted.ready)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = i_reg;
                    state_next  = ssr_pkg::ST_EMIT_LD;
                end
            end

            ssr_pkg::ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_rec_next   = rd_rec;
                out_ovf_next   = drop_reg;
                out_last_next  = (CW'(i_reg) + CW'(1) == count_reg);
                if (CW'(i_reg) + CW'(1) == count_reg)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    i_next     = '0;
                    state_next = ssr_pkg::ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ssr_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ssr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/tb_selection_sort_records.sv
`timescale 1ns / 1ps

module tb_selection_sort_records;

    localparam int SET_CAPACITY  = 64;
    localparam int ID_W          = ssr_pkg::ID_W;
    localparam int SCORE_W       = ssr_pkg::SCORE_W;
    localparam int ITEM_TARGET   = 420;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 10;

    localparam bit [ID_W-1:0]    ID_MAX    = '1;
    localparam bit [ID_W-1:0]    ID_TOP    = 99999999;
    localparam bit [SCORE_W-1:0] SCORE_MAX = '1;
    localparam bit [SCORE_W-1:0] SCORE_TOP = 1000;

    typedef enum bit {
        KEY_ID    = 1'b0,
        KEY_SCORE = 1'b1
    } sort_key_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_RANGE,
        SPREAD_NARROW
    } spread_t;

    typedef struct packed {
        bit [ID_W-1:0]    id;
        bit [SCORE_W-1:0] score;
        bit               last;
    } record_word_t;

    typedef struct packed {
        bit [ID_W-1:0]    id;
        bit [SCORE_W-1:0] score;
        bit               last;
        bit               overflowed;
    } sorted_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ssr_in_if  records_if ();
    ssr_out_if sorted_if ();

    selection_sort_records #(
        .DEPTH (SET_CAPACITY)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .records   (records_if),
        .sorted    (sorted_if)
    );

    // shadow of the record store and set state
    bit [ID_W-1:0]    held_id    [SET_CAPACITY];
    bit [SCORE_W-1:0] held_score [SET_CAPACITY];
    int               held_count;
    bit               held_dropped;
    sort_key_t        key_mode;

    record_word_t pending_words [$];
    sorted_word_t sorted_expect [$];

    int words_queued;
    int words_accepted;
    int error_count;
    bit src_idle_on;
    bit sink_idle_on;
    int hold_requested;
    int hold_granted;
    int hold_left;

    function automatic bit [ID_W-1:0] ordering_key(int k);
        bit [ID_W-1:0] key;
        if (key_mode == KEY_SCORE)
            key = ID_W'(held_score[k]);
        else
            key = held_id[k];
        return key;
    endfunction

    // store one accepted word; on the last word sort the set and queue its output
    task automatic absorb_record(record_word_t w);
        int               best;
        bit [ID_W-1:0]    swap_id;
        bit [SCORE_W-1:0] swap_score;
        sorted_word_t     res;
        if (held_count < SET_CAPACITY)
        begin
            held_id[held_count]    = w.id;
            held_score[held_count] = w.score;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (w.last)
        begin
            for (int i = 0; i + 1 < held_count; i++)
            begin
                best = i;
                for (int j = i + 1; j < held_count; j++)
                    if (ordering_key(j) < ordering_key(best))
                        best = j;
                swap_id          = held_id[best];
                swap_score       = held_score[best];
                held_id[best]    = held_id[i];
                held_score[best] = held_score[i];
                held_id[i]       = swap_id;
                held_score[i]    = swap_score;
            end
            for (int k = 0; k < held_count; k++)
            begin
                res.id         = held_id[k];
                res.score      = held_score[k];
                res.last       = (k == held_count - 1);
                res.overflowed = held_dropped;
                sorted_expect.push_back(res);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic queue_word(bit [ID_W-1:0] id, bit [SCORE_W-1:0] score, bit last);
        record_word_t w;
        w.id    = id;
        w.score = score;
        w.last  = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_random_set(int n);
        spread_t          spread;
        bit [ID_W-1:0]    id_base;
        bit [SCORE_W-1:0] score_base;
        bit [ID_W-1:0]    id;
        bit [SCORE_W-1:0] score;
        spread     = spread_t'($urandom_range(2));
        id_base    = ID_W'($urandom);
        score_base = SCORE_W'($urandom);
        for (int k = 0; k < n; k++)
        begin
            case (spread)
                SPREAD_FULL:
                begin
                    id    = ID_W'($urandom);
                    score = SCORE_W'($urandom);
                end
                SPREAD_RANGE:
                begin
                    id    = ID_W'($urandom_range(ID_TOP));
                    score = SCORE_W'($urandom_range(SCORE_TOP));
                end
                default:
                begin
                    // crowd keys together so ties are common
                    id    = id_base + ID_W'($urandom_range(3));
                    score = score_base + SCORE_W'($urandom_range(3));
                end
            endcase
            queue_word(id, score, k == n - 1);
        end
    endtask

    task automatic wait_until_drained();
        while (words_accepted != words_queued || sorted_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sort_key(sort_key_t mode);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        key_mode   = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // records channel driver
    always @(posedge clk or negedge rst_n)
    begin : drive_records
        record_word_t w;
        if (!rst_n)
        begin
            records_if.valid       <= 1'b0;
            records_if.student_id  <= '0;
            records_if.score       <= '0;
            records_if.last_record <= 1'b0;
        end
        else
        begin
            if (records_if.valid && records_if.ready)
            begin
                w.id    = records_if.student_id;
                w.score = records_if.score;
                w.last  = records_if.last_record;
                absorb_record(w);
                words_accepted++;
            end
            if (!records_if.valid || records_if.ready)
            begin
                if (pending_words.size() != 0 && !(src_idle_on && $urandom_range(99) < 8))
                begin
                    w = pending_words.pop_front();
                    records_if.valid       <= 1'b1;
                    records_if.student_id  <= w.id;
                    records_if.score       <= w.score;
                    records_if.last_record <= w.last;
                end
                else
                    records_if.valid <= 1'b0;
            end
        end
    end

    // sorted channel monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : check_sorted
        sorted_word_t want;
        if (!rst_n)
        begin
            sorted_if.ready <= 1'b0;
            hold_left        = 0;
        end
        else
        begin
            if (sorted_if.valid && sorted_if.ready)
            begin
                if (sorted_expect.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected sorted word id %0d score %0d last %0b ovf %0b",
                             $time, sorted_if.out_id, sorted_if.out_score,
                             sorted_if.out_last, sorted_if.overflowed);
                end
                else
                begin
                    want = sorted_expect.pop_front();
                    if ({sorted_if.out_id, sorted_if.out_score, sorted_if.out_last,
                         sorted_if.overflowed} !== {want.id, want.score, want.last,
                                                    want.overflowed})
                    begin
                        error_count++;
                        $display("%0t: expected id %0d score %0d last %0b ovf %0b, %s",
                                 $time, want.id, want.score, want.last, want.overflowed,
                                 $sformatf("got id %0d score %0d last %0b ovf %0b",
                                           sorted_if.out_id, sorted_if.out_score,
                                           sorted_if.out_last, sorted_if.overflowed));
                    end
                end
            end
            // long hold-off: let the sorter back up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                sorted_if.ready <= 1'b0;
            end
            else if (hold_granted != hold_requested)
            begin
                hold_granted     = hold_requested;
                hold_left        = LONG_HOLD - 1;
                sorted_if.ready <= 1'b0;
            end
            else
                sorted_if.ready <= !(sink_idle_on && $urandom_range(99) < 8);
        end
    end

    initial
    begin
        int phase;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = 1'b0;
        key_mode               = KEY_ID;
        words_queued           = 0;
        hold_requested         = 0;
        src_idle_on            = 1'b1;
        sink_idle_on           = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sort by id: single-word set, then extremes with a tied id
        set_sort_key(KEY_ID);
        queue_word(ID_MAX, SCORE_MAX, 1'b1);
        queue_word(5, 0, 1'b0);
        queue_word(0, SCORE_TOP, 1'b0);
        queue_word(ID_MAX, 1, 1'b0);
        queue_word(5, 7, 1'b0);
        queue_word(ID_TOP, SCORE_MAX, 1'b1);
        wait_until_drained();

        // sort by score: ties, top of range and beyond it
        set_sort_key(KEY_SCORE);
        queue_word(1, SCORE_TOP, 1'b0);
        queue_word(2, 0, 1'b0);
        queue_word(ID_MAX, SCORE_MAX, 1'b0);
        queue_word(4, SCORE_TOP, 1'b0);
        queue_word(0, 0, 1'b0);
        queue_word(6, 512, 1'b1);
        queue_word(ID_MAX, 9, 1'b0);
        queue_word(0, 9, 1'b1);
        wait_until_drained();

        phase = 0;
        while (words_queued < ITEM_TARGET)
        begin
            src_idle_on  = (phase != 2);
            sink_idle_on = (phase != 2);
            set_sort_key(sort_key_t'(phase % 2));
            if (phase == 0)
                hold_requested++;
            if (phase == 3)
            begin
                // full set, last word dropped, trailing words dropped
                queue_random_set(SET_CAPACITY);
                queue_random_set(SET_CAPACITY + 1);
                queue_random_set(SET_CAPACITY + 2);
            end
            repeat ($urandom_range(4, 8))
                queue_random_set(($urandom_range(3) != 0) ? $urandom_range(1, 8)
                                                            : $urandom_range(9, 24));
            wait_until_drained();
            phase++;
        end

        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
